>>> rtl/latency_path_timestamp_table_top_defines.svh
// Assertion macros for the path timestamp table
`ifndef LATENCY_PATH_TIMESTAMP_TABLE_TOP_DEFINES_SVH
`define LATENCY_PATH_TIMESTAMP_TABLE_TOP_DEFINES_SVH
`ifndef SYNTH
// Check a condition in the same cycle as its trigger
`define LPTT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lptt check failed");
// Check a condition in the cycle after its trigger
`define LPTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lptt check failed");
`else
`define LPTT_ASSERT_NOW(lbl, ante, cons)
`define LPTT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lptt_pkg.sv
package lptt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int OCC_W = 7;
  localparam int ID_W  = 64;
  localparam int TS_W  = 64;
  localparam int CMD_W = 3;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_TICK     = CMD_W'(0);
  localparam cmd_t CMD_DECISION = CMD_W'(1);
  localparam cmd_t CMD_ROUTE    = CMD_W'(2);
  localparam cmd_t CMD_ACK      = CMD_W'(3);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan_en;
    logic read_en;
    logic commit;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/lptt_ctrl.sv
module lptt_ctrl import lptt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Accept only when no transaction is in flight
  assign in_stall = (state_r != ST_IDLE);

  // Issue datapath commands per state
  always_comb begin
    ctrl.load    = (state_r == ST_IDLE) && in_valid;
    ctrl.scan_en = (state_r == ST_SCAN);
    ctrl.read_en = (state_r == ST_READ);
    ctrl.commit  = (state_r == ST_UPD) && sts.out_free;
  end

  // Advance through scan, compare drain, slot read and update
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_UPD;
      ST_UPD:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/lptt_dp.sv
module lptt_dp import lptt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        ctrl,
  output dp_status_t       sts,
  input  cmd_t             in_cmd,
  input  logic [ID_W-1:0]  in_path_id,
  input  logic [TS_W-1:0]  in_timestamp,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [TS_W-1:0]  out_tick_time,
  output logic [TS_W-1:0]  out_decision_time,
  output logic [TS_W-1:0]  out_route_time,
  output logic [TS_W-1:0]  out_ack_time,
  output logic [OCC_W-1:0] out_occupancy
);

  // Entry storage
  logic [ID_W-1:0] id_mem    [TABLE_ENTRIES];
  logic [TS_W-1:0] tick_mem  [TABLE_ENTRIES];
  logic [TS_W-1:0] dec_mem   [TABLE_ENTRIES];
  logic [TS_W-1:0] route_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Latched transaction
  cmd_t            cmd_r;
  logic [ID_W-1:0] id_r;
  logic [TS_W-1:0] ts_r;

  // Scan pipeline
  logic [IDX_W-1:0] scan_idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [ID_W-1:0]  rd_id_r;
  logic             cmp_match;
  logic             hit_r;
  logic [IDX_W-1:0] hit_slot_r;
  logic             free_seen_r;
  logic [IDX_W-1:0] free_slot_r;
  logic             vld_seen_r;
  logic [IDX_W-1:0] vld_slot_r;

  // Slot access
  logic [IDX_W-1:0] slot_sel;
  logic [IDX_W-1:0] slot_r;
  logic [TS_W-1:0]  rd_tick_r;
  logic [TS_W-1:0]  rd_dec_r;
  logic [TS_W-1:0]  rd_route_r;

  // Update terms
  logic            full;
  logic            is_tick;
  logic            is_dec;
  logic            is_route;
  logic            is_ack;
  logic            new_entry;
  logic [TS_W-1:0] res_tick;
  logic [TS_W-1:0] res_dec;
  logic [TS_W-1:0] res_route;
  logic [TS_W-1:0] res_ack;

  // Output register
  logic             out_valid_r;
  logic             out_found_r;
  logic [TS_W-1:0]  out_tick_r;
  logic [TS_W-1:0]  out_dec_r;
  logic [TS_W-1:0]  out_route_r;
  logic [TS_W-1:0]  out_ack_r;
  logic [OCC_W-1:0] out_occ_r;

  assign full      = (count_r >= CNT_W'(TABLE_ENTRIES));
  assign cmp_match = cmp_vld_r && valid_r[cmp_idx_r] && (rd_id_r == id_r);

  assign sts.scan_last = (scan_idx_r == IDX_W'(TABLE_ENTRIES - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Pick the slot: hit, else evict lowest valid when full, else lowest free
  always_comb begin
    if (hit_r) begin
      slot_sel = hit_slot_r;
    end else if (full) begin
      slot_sel = vld_slot_r;
    end else begin
      slot_sel = free_slot_r;
    end
  end

  // Decode command and form the result
  always_comb begin
    is_tick   = (cmd_r == CMD_TICK);
    is_dec    = (cmd_r == CMD_DECISION);
    is_route  = (cmd_r == CMD_ROUTE);
    is_ack    = (cmd_r == CMD_ACK);
    new_entry = is_tick && !hit_r;

    res_tick = is_tick ? ts_r : (hit_r ? rd_tick_r : '0);

    if (new_entry || !hit_r) begin
      res_dec = '0;
    end else if (is_dec) begin
      res_dec = ts_r;
    end else begin
      res_dec = rd_dec_r;
    end

    if (new_entry || !hit_r) begin
      res_route = '0;
    end else if (is_route) begin
      res_route = ts_r;
    end else begin
      res_route = rd_route_r;
    end

    res_ack = (is_ack && hit_r) ? ts_r : '0;

    count_nxt = count_r;
    if (new_entry && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (is_ack && hit_r) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Capture transaction and step the scan
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_path_id;
      ts_r  <= in_timestamp;
    end
    if (ctrl.load) begin
      scan_idx_r <= '0;
    end else if (ctrl.scan_en) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    if (ctrl.scan_en) begin
      cmp_idx_r <= scan_idx_r;
    end
    if (ctrl.load) begin
      hit_r       <= 1'b0;
      free_seen_r <= 1'b0;
      vld_seen_r  <= 1'b0;
      hit_slot_r  <= '0;
      free_slot_r <= '0;
      vld_slot_r  <= '0;
    end else if (cmp_vld_r) begin
      if (cmp_match && !hit_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= cmp_idx_r;
      end
      if (!valid_r[cmp_idx_r] && !free_seen_r) begin
        free_seen_r <= 1'b1;
        free_slot_r <= cmp_idx_r;
      end
      if (valid_r[cmp_idx_r] && !vld_seen_r) begin
        vld_seen_r <= 1'b1;
        vld_slot_r <= cmp_idx_r;
      end
    end
    if (ctrl.read_en) begin
      slot_r <= slot_sel;
    end
  end

  // Read and write the entry memories
  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      rd_id_r <= id_mem[scan_idx_r];
    end
    if (ctrl.read_en) begin
      rd_tick_r  <= tick_mem[slot_sel];
      rd_dec_r   <= dec_mem[slot_sel];
      rd_route_r <= route_mem[slot_sel];
    end
    if (ctrl.commit && new_entry) begin
      id_mem[slot_r] <= id_r;
    end
    if (ctrl.commit && is_tick) begin
      tick_mem[slot_r] <= ts_r;
    end
    if (ctrl.commit && (new_entry || (is_dec && hit_r))) begin
      dec_mem[slot_r] <= res_dec;
    end
    if (ctrl.commit && (new_entry || (is_route && hit_r))) begin
      route_mem[slot_r] <= res_route;
    end
  end

  // Hold control state: valid bits, count, compare flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= ctrl.scan_en;
      if (ctrl.commit) begin
        count_r <= count_nxt;
        if (new_entry) begin
          valid_r[slot_r] <= 1'b1;
        end else if (is_ack && hit_r) begin
          valid_r[slot_r] <= 1'b0;
        end
      end
      if (ctrl.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_found_r <= hit_r;
      out_tick_r  <= res_tick;
      out_dec_r   <= res_dec;
      out_route_r <= res_route;
      out_ack_r   <= res_ack;
      out_occ_r   <= OCC_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_tick_time     = out_tick_r;
  assign out_decision_time = out_dec_r;
  assign out_route_time    = out_route_r;
  assign out_ack_time      = out_ack_r;
  assign out_occupancy     = out_occ_r;

endmodule

>>> rtl/latency_path_timestamp_table_top.sv
// Flow: a transaction goes from accept to result in the output register through the
// id scan, which steps one slot per cycle over the id memory read port, then a
// compare drain, a slot read and an update step that waits while a result is held.
// A new transaction is taken only once the last has committed; a waiting result does
// not block the next accept. Reset clears the valid bits, count and all control
// state at once; entry memories are not cleared and no clearing pass runs.
`include "latency_path_timestamp_table_top_defines.svh"
module latency_path_timestamp_table_top import lptt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [ID_W-1:0]  in_path_id,
  input  logic [TS_W-1:0]  in_timestamp,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output logic [TS_W-1:0]  out_tick_time,
  output logic [TS_W-1:0]  out_decision_time,
  output logic [TS_W-1:0]  out_route_time,
  output logic [TS_W-1:0]  out_ack_time,
  output logic [OCC_W-1:0] out_occupancy
);

  ctrl_cmd_t  ctrl;
  dp_status_t sts;

  lptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctrl     (ctrl)
  );

  lptt_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_path_id        (in_path_id),
    .in_timestamp      (in_timestamp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_tick_time     (out_tick_time),
    .out_decision_time (out_decision_time),
    .out_route_time    (out_route_time),
    .out_ack_time      (out_ack_time),
    .out_occupancy     (out_occupancy)
  );

  // Busy right after an accepted transaction
  `LPTT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // A committed result shows up on the output
  `LPTT_ASSERT_NEXT(a_commit_shows, ctrl.commit, out_valid)
  // A nonzero ack time only comes from a found id
  `LPTT_ASSERT_NOW(a_ack_needs_found, out_valid && (out_ack_time != '0), out_found)
  // Absent or new ids report clear decision and route times
  `LPTT_ASSERT_NOW(a_absent_zero, out_valid && !out_found, (out_decision_time | out_route_time) == '0)

endmodule
